// ----- rtl/i2cee_pkg.sv -----
package i2cee_pkg;

    // Default sizes, handed to the top level parameters
    localparam int PAGE_BYTES_DEF   = 8;
    localparam int MAX_READ_LEN_DEF = 128;

    // Fixed width of the byte counter, and the bit count of a byte
    localparam int BCNT_W = 8;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Configuration register indexes and reset values
    localparam logic       CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic       CFG_ACK_WAIT_TICKS = 1'b1;
    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;
    localparam logic [3:0] ACK_WAIT_TICKS_RST = 4'd4;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_ACK = 2'd1,
        ST_BUSY   = 2'd2
    } t_status;

    // Half-bit bus phases, one-hot
    typedef enum logic [14:0] {
        PH_IDLE     = 15'h0001,
        PH_RS_LOW   = 15'h0002,
        PH_ST_HIGH  = 15'h0004,
        PH_ST_LOW   = 15'h0008,
        PH_TX_LOW   = 15'h0010,
        PH_TX_HIGH  = 15'h0020,
        PH_ACK_LOW  = 15'h0040,
        PH_ACK_HIGH = 15'h0080,
        PH_RX_LOW   = 15'h0100,
        PH_RX_HIGH  = 15'h0200,
        PH_MA_LOW   = 15'h0400,
        PH_MA_HIGH  = 15'h0800,
        PH_SP_A     = 15'h1000,
        PH_SP_B     = 15'h2000,
        PH_SP_C     = 15'h4000
    } t_phase;

    // One input request
    typedef struct packed {
        t_action    action;
        logic       sda_in;
        logic [7:0] mem_address;
        logic [7:0] transfer_len;
        logic [2:0] buffer_slot;
        logic [7:0] data_byte;
    } t_item;

    // One result
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic [6:0] read_index;
        logic       done_res;
        t_status    status;
    } t_result;

endpackage

// ----- rtl/i2cee_engine.sv -----
module i2cee_engine #(
    parameter int PAGE_BYTES   = 8,
    parameter int MAX_READ_LEN = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cee_pkg::t_item   i_item,
    input  logic [6:0]         i_device_address,
    input  logic [3:0]         i_ack_wait_ticks,
    output i2cee_pkg::t_result o_result
);
    import i2cee_pkg::*;

    localparam int MAX_LEN = (MAX_READ_LEN > PAGE_BYTES) ? MAX_READ_LEN : PAGE_BYTES;
    localparam int LEFT_W  = $clog2(MAX_LEN + 1);
    localparam int SLOT_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

    // Transfer state
    t_phase              r_phase, n_phase;
    logic [3:0]          r_bit_count, n_bit_count;
    logic [7:0]          r_shift_byte, n_shift_byte;
    logic [BCNT_W-1:0]   r_byte_count, n_byte_count;
    logic [LEFT_W-1:0]   r_length_left, n_length_left;
    logic [7:0]          r_word_address, n_word_address;
    logic                r_is_read, n_is_read;
    logic [3:0]          r_ack_wait_count, n_ack_wait_count;
    logic                r_scl_level, n_scl_level;
    logic                r_sda_level, n_sda_level;
    logic                r_abort, n_abort;
    logic [7:0]          r_page_buffer [PAGE_BYTES];

    logic                buf_we;
    logic [SLOT_W-1:0]   buf_wr_slot;
    logic [BCNT_W-1:0]   tx_count;
    logic [SLOT_W-1:0]   tx_slot;
    logic [7:0]          tx_byte;
    logic                tx_dec;
    logic [LEFT_W-1:0]   rd_len;
    logic [LEFT_W-1:0]   wr_len;
    logic [3:0]          bit_inc;
    logic [7:0]          rx_shift;
    t_result             res;

    // Byte counter seen by the next-byte loader: after an ACK it is one ahead
    assign tx_count = (r_phase == PH_ACK_HIGH) ? (r_byte_count + BCNT_W'(1)) : r_byte_count;
    assign tx_slot  = SLOT_W'(tx_count - BCNT_W'(2));
    assign tx_dec   = (tx_count >= BCNT_W'(2)) && !r_is_read
                      && (r_length_left != LEFT_W'(0));

    // Next byte to shift out
    always_comb begin
        if (tx_count == BCNT_W'(0)) begin
            tx_byte = {i_device_address, 1'b0};
        end else if (tx_count == BCNT_W'(1)) begin
            tx_byte = r_word_address;
        end else if (r_is_read) begin
            tx_byte = {i_device_address, 1'b1};
        end else begin
            tx_byte = r_page_buffer[tx_slot];
        end
    end

    // Clamped lengths of a start request
    assign rd_len = ({1'b0, i_item.transfer_len} > 9'(MAX_READ_LEN))
                    ? LEFT_W'(MAX_READ_LEN) : LEFT_W'(i_item.transfer_len);
    assign wr_len = ({1'b0, i_item.transfer_len} > 9'(PAGE_BYTES))
                    ? LEFT_W'(PAGE_BYTES) : LEFT_W'(i_item.transfer_len);

    assign bit_inc     = r_bit_count + 4'd1;
    assign rx_shift    = {r_shift_byte[6:0], i_item.sda_in};
    assign buf_wr_slot = SLOT_W'(i_item.buffer_slot);

    // Step logic: one request against the current state
    always_comb begin
        n_phase          = r_phase;
        n_bit_count      = r_bit_count;
        n_shift_byte     = r_shift_byte;
        n_byte_count     = r_byte_count;
        n_length_left    = r_length_left;
        n_word_address   = r_word_address;
        n_is_read        = r_is_read;
        n_ack_wait_count = r_ack_wait_count;
        n_scl_level      = r_scl_level;
        n_sda_level      = r_sda_level;
        n_abort          = r_abort;
        buf_we           = 1'b0;
        res              = '0;
        res.status       = ST_OK;

        if (i_item.action != ACT_TICK) begin
            if (r_phase != PH_IDLE) begin
                res.status = ST_BUSY;
            end else if (i_item.action == ACT_LOAD) begin
                buf_we = (32'(i_item.buffer_slot) < PAGE_BYTES);
            end else begin
                n_is_read        = (i_item.action == ACT_READ);
                n_word_address   = i_item.mem_address;
                n_byte_count     = '0;
                n_bit_count      = '0;
                n_ack_wait_count = '0;
                n_abort          = 1'b0;
                if (i_item.action == ACT_READ) begin
                    n_length_left = rd_len;
                    if (rd_len == LEFT_W'(0)) begin
                        res.done_res = 1'b1;
                    end else begin
                        n_phase = PH_ST_HIGH;
                    end
                end else begin
                    n_length_left = wr_len;
                    n_phase       = PH_ST_HIGH;
                end
            end
        end else begin
            unique case (r_phase)
                PH_RS_LOW: begin
                    n_scl_level = 1'b0;
                    n_sda_level = 1'b1;
                    n_phase     = PH_ST_HIGH;
                end
                PH_ST_HIGH: begin
                    n_scl_level = 1'b1;
                    n_sda_level = 1'b1;
                    n_phase     = PH_ST_LOW;
                end
                PH_ST_LOW: begin
                    n_scl_level  = 1'b1;
                    n_sda_level  = 1'b0;
                    n_shift_byte = tx_byte;
                    n_bit_count  = '0;
                    if (tx_dec) n_length_left = r_length_left - LEFT_W'(1);
                    n_phase      = PH_TX_LOW;
                end
                PH_TX_LOW: begin
                    n_scl_level = 1'b0;
                    n_sda_level = r_shift_byte[7];
                    n_phase     = PH_TX_HIGH;
                end
                PH_TX_HIGH: begin
                    n_scl_level  = 1'b1;
                    n_shift_byte = {r_shift_byte[6:0], 1'b0};
                    n_bit_count  = bit_inc;
                    n_phase      = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
                end
                PH_ACK_LOW: begin
                    n_scl_level      = 1'b0;
                    n_sda_level      = 1'b1;
                    n_ack_wait_count = '0;
                    n_phase          = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    n_scl_level = 1'b1;
                    n_sda_level = 1'b1;
                    if (!i_item.sda_in) begin
                        n_byte_count = tx_count;
                        if (r_is_read) begin
                            if (tx_count == BCNT_W'(2)) begin
                                n_phase = PH_RS_LOW;
                            end else begin
                                n_byte_count = '0;
                                n_bit_count  = '0;
                                n_shift_byte = '0;
                                n_phase      = PH_RX_LOW;
                            end
                        end else if (tx_count >= BCNT_W'(2)
                                     && r_length_left == LEFT_W'(0)) begin
                            n_phase = PH_SP_A;
                        end else begin
                            n_shift_byte = tx_byte;
                            n_bit_count  = '0;
                            if (tx_dec) n_length_left = r_length_left - LEFT_W'(1);
                            n_phase      = PH_TX_LOW;
                        end
                    end else if (r_ack_wait_count < i_ack_wait_ticks) begin
                        n_ack_wait_count = r_ack_wait_count + 4'd1;
                    end else begin
                        n_abort = 1'b1;
                        n_phase = PH_SP_A;
                    end
                end
                PH_RX_LOW: begin
                    n_scl_level = 1'b0;
                    n_sda_level = 1'b1;
                    n_phase     = PH_RX_HIGH;
                end
                PH_RX_HIGH: begin
                    n_scl_level  = 1'b1;
                    n_sda_level  = 1'b1;
                    n_shift_byte = rx_shift;
                    n_bit_count  = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        res.read_valid = 1'b1;
                        res.read_data  = rx_shift;
                        res.read_index = r_byte_count[6:0];
                        if (r_length_left != LEFT_W'(0)) begin
                            n_length_left = r_length_left - LEFT_W'(1);
                        end
                        n_phase = PH_MA_LOW;
                    end else begin
                        n_phase = PH_RX_LOW;
                    end
                end
                PH_MA_LOW: begin
                    // NACK the last byte, ACK the others
                    n_scl_level = 1'b0;
                    n_sda_level = (r_length_left == LEFT_W'(0));
                    n_phase     = PH_MA_HIGH;
                end
                PH_MA_HIGH: begin
                    n_scl_level = 1'b1;
                    if (r_length_left == LEFT_W'(0)) begin
                        n_phase = PH_SP_A;
                    end else begin
                        n_byte_count = r_byte_count + BCNT_W'(1);
                        n_bit_count  = '0;
                        n_shift_byte = '0;
                        n_phase      = PH_RX_LOW;
                    end
                end
                PH_SP_A: begin
                    n_scl_level = 1'b0;
                    n_sda_level = 1'b0;
                    n_phase     = PH_SP_B;
                end
                PH_SP_B: begin
                    n_scl_level = 1'b1;
                    n_sda_level = 1'b0;
                    n_phase     = PH_SP_C;
                end
                PH_SP_C: begin
                    n_scl_level  = 1'b1;
                    n_sda_level  = 1'b1;
                    n_phase      = PH_IDLE;
                    res.done_res = 1'b1;
                    res.status   = r_abort ? ST_NO_ACK : ST_OK;
                end
                default: begin
                    n_phase     = PH_IDLE;
                    n_scl_level = 1'b1;
                    n_sda_level = 1'b1;
                end
            endcase
        end

        res.scl_out  = n_scl_level;
        res.sda_out  = n_sda_level;
        res.busy_res = (n_phase != PH_IDLE);
    end

    assign o_result = res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_bit_count      <= '0;
            r_shift_byte     <= '0;
            r_byte_count     <= '0;
            r_length_left    <= '0;
            r_word_address   <= '0;
            r_is_read        <= 1'b0;
            r_ack_wait_count <= '0;
            r_scl_level      <= 1'b1;
            r_sda_level      <= 1'b1;
            r_abort          <= 1'b0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_bit_count      <= n_bit_count;
            r_shift_byte     <= n_shift_byte;
            r_byte_count     <= n_byte_count;
            r_length_left    <= n_length_left;
            r_word_address   <= n_word_address;
            r_is_read        <= n_is_read;
            r_ack_wait_count <= n_ack_wait_count;
            r_scl_level      <= n_scl_level;
            r_sda_level      <= n_sda_level;
            r_abort          <= n_abort;
        end
    end

    // Page buffer, no reset
    always_ff @(posedge i_clk) begin
        if (i_step && buf_we) begin
            r_page_buffer[buf_wr_slot] <= i_item.data_byte;
        end
    end

endmodule

// ----- rtl/i2c_eeprom_master.sv -----
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_ready  action, sda_in, mem_address, transfer_len,
//                                               buffer_slot, data_byte
// out       output     o_out_valid / i_out_ready scl_out, sda_out, busy_res, read_valid,
//                                               read_data, read_index, done_res, status
// cfg       input      i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
// One request per clock sustained while the result channel is not stalled; a result passes
// the input register, then the step logic into the result register.
// The bus state updates once per request, in the cycle it leaves the input register.
// Reset (synchronous, active low) returns the bus to idle with both lines released.
// A stalled result holds the output register; the input register still takes a request
// while it is empty, and input ready drops only when both registers are full.
module i2c_eeprom_master #(
    parameter int PAGE_BYTES   = i2cee_pkg::PAGE_BYTES_DEF,
    parameter int MAX_READ_LEN = i2cee_pkg::MAX_READ_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic       i_sda_in,
    input  logic [7:0] i_mem_address,
    input  logic [7:0] i_transfer_len,
    input  logic [2:0] i_buffer_slot,
    input  logic [7:0] i_data_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_read_valid,
    output logic [7:0] o_read_data,
    output logic [6:0] o_read_index,
    output logic       o_done_res,
    output logic [1:0] o_status,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data
);
    import i2cee_pkg::*;

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    logic [6:0] r_device_address;
    logic [3:0] r_ack_wait_ticks;

    logic       step;
    t_result    step_result;

    // Input register advances when the result register is free or being drained
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.action       <= t_action'(i_action);
            r_in.sda_in       <= i_sda_in;
            r_in.mem_address  <= i_mem_address;
            r_in.transfer_len <= i_transfer_len;
            r_in.buffer_slot  <= i_buffer_slot;
            r_in.data_byte    <= i_data_byte;
        end
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RST;
            r_ack_wait_ticks <= ACK_WAIT_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data;
                CFG_ACK_WAIT_TICKS: r_ack_wait_ticks <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Bus sequencer
    i2cee_engine #(
        .PAGE_BYTES   (PAGE_BYTES),
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_item           (r_in),
        .i_device_address (r_device_address),
        .i_ack_wait_ticks (r_ack_wait_ticks),
        .o_result         (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_out    = r_out.scl_out;
    assign o_sda_out    = r_out.sda_out;
    assign o_busy_res   = r_out.busy_res;
    assign o_read_valid = r_out.read_valid;
    assign o_read_data  = r_out.read_data;
    assign o_read_index = r_out.read_index;
    assign o_done_res   = r_out.done_res;
    assign o_status     = r_out.status;

endmodule
